### hw/rtl/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants for the open-drain I2C bit-level master.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  // Command codes carried in the operation field
  localparam logic [2:0] OpTick  = 3'd0;
  localparam logic [2:0] OpStart = 3'd1;
  localparam logic [2:0] OpStop  = 3'd2;
  localparam logic [2:0] OpWrite = 3'd3;
  localparam logic [2:0] OpRead  = 3'd4;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgShortWait = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgLongWait  = 1'd1;

  localparam int unsigned WaitW = 16;
  localparam logic [WaitW-1:0] ShortWaitRst = 16'd3;
  localparam logic [WaitW-1:0] LongWaitRst  = 16'd5;

  // Top bit of a byte; bits go out MSB first
  localparam logic [7:0] MsbMask = 8'h80;

  // One tick word on the command side
  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       scl_in;
    logic       sda_in;
  } item_t;

  // One result word per tick
  typedef struct packed {
    logic       scl_drive_low;
    logic       sda_drive_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_seen;
    logic       refused;
  } result_t;

endpackage

### hw/rtl/i2cm_if.sv
// ----------------------------------------------------------------------------
// i2cm_if
// Valid/ready channels of the I2C bit-level master: tick command words,
// result words and configuration writes.
// ----------------------------------------------------------------------------
interface i2cm_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [7:0] tx_byte;
  logic       send_ack;
  logic       scl_in;
  logic       sda_in;

  modport source (output valid, operation, tx_byte, send_ack, scl_in, sda_in,
                  input ready);
  modport sink   (input valid, operation, tx_byte, send_ack, scl_in, sda_in,
                  output ready);
endinterface

interface i2cm_res_if;
  logic       valid;
  logic       ready;
  logic       scl_drive_low;
  logic       sda_drive_low;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       ack_seen;
  logic       refused;

  modport source (output valid, scl_drive_low, sda_drive_low, busy_res, done_res,
                  rx_byte, ack_seen, refused, input ready);
  modport sink   (input valid, scl_drive_low, sda_drive_low, busy_res, done_res,
                  rx_byte, ack_seen, refused, output ready);
endinterface

interface i2cm_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/i2c_bit_level_master.sv
// Open-drain I2C bit-level master. Each command word is one timing tick; the
// block takes one word every clock unless the result side stalls, and returns
// one result word per tick through the input register, then the sequencer's
// output register, after a single pass through the phase sequencer. Bus timing
// is counted in ticks: short_wait (index 0) and long_wait (index 1) set the
// hold after each pin action. Write them only while no word is in flight.
// ----------------------------------------------------------------------------
// i2c_bit_level_master
// Top level: configuration registers, input register and bus sequencer.
// ----------------------------------------------------------------------------
module i2c_bit_level_master (
  input  logic       clk_i,
  input  logic       rst_ni,
  i2cm_cmd_if.sink   cmd_i,
  i2cm_res_if.source res_o,
  i2cm_cfg_if.sink   cfg_i
);

  logic [i2cm_pkg::WaitW-1:0] short_wait_q;
  logic [i2cm_pkg::WaitW-1:0] long_wait_q;
  logic                       in_valid_q;
  i2cm_pkg::item_t            item_q;
  i2cm_pkg::result_t          res;
  logic                       seq_ready;
  logic                       cmd_fire;

  // Configuration writes are always taken
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_wait_q <= i2cm_pkg::ShortWaitRst;
      long_wait_q  <= i2cm_pkg::LongWaitRst;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        i2cm_pkg::CfgShortWait: short_wait_q <= cfg_i.data;
        i2cm_pkg::CfgLongWait:  long_wait_q  <= cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  // Input register: take a new word whenever it is empty or the held one moves on
  assign cmd_i.ready = !in_valid_q || seq_ready;
  assign cmd_fire    = cmd_i.valid && cmd_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (cmd_i.ready) begin
      in_valid_q <= cmd_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_fire) begin
      item_q.operation <= cmd_i.operation;
      item_q.tx_byte   <= cmd_i.tx_byte;
      item_q.send_ack  <= cmd_i.send_ack;
      item_q.scl_in    <= cmd_i.scl_in;
      item_q.sda_in    <= cmd_i.sda_in;
    end
  end

  i2cm_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_valid_i (in_valid_q),
    .step_ready_o (seq_ready),
    .item_i       (item_q),
    .short_wait_i (short_wait_q),
    .long_wait_i  (long_wait_q),
    .res_valid_o  (res_o.valid),
    .res_ready_i  (res_o.ready),
    .res_o        (res)
  );

  // Drive the result channel
  assign res_o.scl_drive_low = res.scl_drive_low;
  assign res_o.sda_drive_low = res.sda_drive_low;
  assign res_o.busy_res      = res.busy_res;
  assign res_o.done_res      = res.done_res;
  assign res_o.rx_byte       = res.rx_byte;
  assign res_o.ack_seen      = res.ack_seen;
  assign res_o.refused       = res.refused;

endmodule

### hw/rtl/i2cm_seq.sv
// ----------------------------------------------------------------------------
// i2cm_seq
// Bus sequencer: applies one tick word to the phase, counters and pin pulls
// and loads the result word into the output register.
// ----------------------------------------------------------------------------
module i2cm_seq (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_valid_i,
  output logic                         step_ready_o,
  input  i2cm_pkg::item_t              item_i,
  input  logic [i2cm_pkg::WaitW-1:0]   short_wait_i,
  input  logic [i2cm_pkg::WaitW-1:0]   long_wait_i,
  output logic                         res_valid_o,
  input  logic                         res_ready_i,
  output i2cm_pkg::result_t            res_o
);

  // Phase codes
  localparam logic [4:0] PhIdle      = 5'd0;
  localparam logic [4:0] PhSRelScl   = 5'd1;
  localparam logic [4:0] PhSPullSda  = 5'd2;
  localparam logic [4:0] PhPPullSda  = 5'd3;
  localparam logic [4:0] PhPRelScl   = 5'd4;
  localparam logic [4:0] PhPRelSda   = 5'd5;
  localparam logic [4:0] PhWSclLow   = 5'd6;
  localparam logic [4:0] PhWSetSda   = 5'd7;
  localparam logic [4:0] PhWSclHigh  = 5'd8;
  localparam logic [4:0] PhWStretch  = 5'd9;
  localparam logic [4:0] PhWaSclLow  = 5'd10;
  localparam logic [4:0] PhWaRelSda  = 5'd11;
  localparam logic [4:0] PhWaSclHigh = 5'd12;
  localparam logic [4:0] PhWaStretch = 5'd13;
  localparam logic [4:0] PhWaSclLow2 = 5'd14;
  localparam logic [4:0] PhRSclLow   = 5'd15;
  localparam logic [4:0] PhRSclHigh  = 5'd16;
  localparam logic [4:0] PhRStretch  = 5'd17;
  localparam logic [4:0] PhRaSclLow  = 5'd18;
  localparam logic [4:0] PhRaSetSda  = 5'd19;
  localparam logic [4:0] PhRaSclHigh = 5'd20;
  localparam logic [4:0] PhRaSclLow2 = 5'd21;

  logic [4:0]                  phase_q, phase_d;
  logic [i2cm_pkg::WaitW-1:0]  wait_q, wait_d;
  logic [3:0]                  bit_q, bit_d;
  logic [7:0]                  shift_q, shift_d;
  logic                        ack_flag_q, ack_flag_d;
  logic [7:0]                  recv_q, recv_d;
  logic                        scl_q, scl_d;
  logic                        sda_q, sda_d;
  logic                        ack_send_q, ack_send_d;
  logic                        out_valid_q;
  i2cm_pkg::result_t           res_q, res_d;

  logic       step_fire;
  logic       is_cmd;
  logic       done;
  logic       refused;
  logic       go;
  logic [4:0] ent;

  assign step_ready_o = !out_valid_q || res_ready_i;
  assign step_fire    = step_valid_i && step_ready_o;

  assign is_cmd = (item_i.operation == i2cm_pkg::OpStart) ||
                  (item_i.operation == i2cm_pkg::OpStop)  ||
                  (item_i.operation == i2cm_pkg::OpWrite) ||
                  (item_i.operation == i2cm_pkg::OpRead);

  // Advance the sequencer by one tick
  always_comb begin
    phase_d    = phase_q;
    wait_d     = wait_q;
    bit_d      = bit_q;
    shift_d    = shift_q;
    ack_flag_d = ack_flag_q;
    recv_d     = recv_q;
    scl_d      = scl_q;
    sda_d      = sda_q;
    ack_send_d = ack_send_q;
    done       = 1'b0;
    refused    = 1'b0;
    go         = 1'b0;
    ent        = PhIdle;

    if (phase_q == PhIdle) begin
      case (item_i.operation)
        i2cm_pkg::OpStart: begin
          go  = 1'b1;
          ent = PhSRelScl;
        end
        i2cm_pkg::OpStop: begin
          go  = 1'b1;
          ent = PhPPullSda;
        end
        i2cm_pkg::OpWrite: begin
          shift_d = item_i.tx_byte;
          bit_d   = 4'd0;
          go      = 1'b1;
          ent     = PhWSclLow;
        end
        i2cm_pkg::OpRead: begin
          shift_d    = 8'd0;
          bit_d      = 4'd0;
          ack_send_d = item_i.send_ack;
          go         = 1'b1;
          ent        = PhRSclLow;
        end
        default: begin
        end
      endcase
    end else begin
      refused = is_cmd;
      if (phase_q == PhWStretch) begin
        // Wait for SCL high, then move to the next bit or to the acknowledge
        if (item_i.scl_in) begin
          shift_d = {shift_q[6:0], 1'b0};
          bit_d   = bit_q + 4'd1;
          go      = 1'b1;
          ent     = (bit_d < 4'd8) ? PhWSclLow : PhWaSclLow;
        end
      end else if (phase_q == PhWaStretch) begin
        // Sample the slave acknowledge
        if (item_i.scl_in) begin
          ack_flag_d = !item_i.sda_in;
          go         = 1'b1;
          ent        = PhWaSclLow2;
        end
      end else if (phase_q == PhRStretch) begin
        // Shift in one data bit
        if (item_i.scl_in) begin
          if (item_i.sda_in) begin
            shift_d = shift_q | (i2cm_pkg::MsbMask >> bit_q[2:0]);
          end
          bit_d = bit_q + 4'd1;
          go    = 1'b1;
          ent   = (bit_d < 4'd8) ? PhRSclLow : PhRaSclLow;
        end
      end else if (wait_q > 16'd1) begin
        wait_d = wait_q - 16'd1;
      end else if ((phase_q == PhSPullSda) || (phase_q == PhPRelSda) ||
                   (phase_q == PhWaSclLow2) || (phase_q == PhRaSclLow2)) begin
        if (phase_q == PhRaSclLow2) begin
          recv_d = shift_q;
        end
        phase_d = PhIdle;
        wait_d  = '0;
        done    = 1'b1;
      end else begin
        go  = 1'b1;
        ent = phase_q + 5'd1;
      end
    end

    // Perform the pin action of the entered phase and load its hold time
    if (go) begin
      phase_d = ent;
      wait_d  = '0;
      case (ent)
        PhSRelScl:   begin scl_d = 1'b0; wait_d = long_wait_i;  end
        PhSPullSda:  begin sda_d = 1'b1; wait_d = long_wait_i;  end
        PhPPullSda:  begin sda_d = 1'b1; wait_d = long_wait_i;  end
        PhPRelScl:   begin scl_d = 1'b0; wait_d = short_wait_i; end
        PhPRelSda:   begin sda_d = 1'b0; wait_d = long_wait_i;  end
        PhWSclLow:   begin scl_d = 1'b1; wait_d = short_wait_i; end
        PhWSetSda:   begin
          sda_d  = !shift_d[7];
          wait_d = long_wait_i;
        end
        PhWSclHigh:  begin scl_d = 1'b0; wait_d = long_wait_i;  end
        PhWaSclLow:  begin scl_d = 1'b1; wait_d = short_wait_i; end
        PhWaRelSda:  begin sda_d = 1'b0; wait_d = long_wait_i;  end
        PhWaSclHigh: begin scl_d = 1'b0; wait_d = long_wait_i;  end
        PhWaSclLow2: begin scl_d = 1'b1; wait_d = long_wait_i;  end
        PhRSclLow:   begin scl_d = 1'b1; wait_d = long_wait_i;  end
        PhRSclHigh:  begin scl_d = 1'b0; wait_d = long_wait_i;  end
        PhRaSclLow:  begin scl_d = 1'b1; wait_d = short_wait_i; end
        PhRaSetSda:  begin sda_d = ack_send_d; wait_d = long_wait_i; end
        PhRaSclHigh: begin scl_d = 1'b0; wait_d = long_wait_i;  end
        PhRaSclLow2: begin scl_d = 1'b1; wait_d = long_wait_i;  end
        default: begin
        end
      endcase
    end
  end

  // Build the result word from the updated state
  always_comb begin
    res_d.scl_drive_low = scl_d;
    res_d.sda_drive_low = sda_d;
    res_d.busy_res      = (phase_d != PhIdle);
    res_d.done_res      = done;
    res_d.rx_byte       = recv_d;
    res_d.ack_seen      = ack_flag_d;
    res_d.refused       = refused;
  end

  // Commit state on each accepted tick word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhIdle;
      wait_q     <= '0;
      bit_q      <= '0;
      shift_q    <= '0;
      ack_flag_q <= 1'b0;
      recv_q     <= '0;
      scl_q      <= 1'b0;
      sda_q      <= 1'b0;
      ack_send_q <= 1'b0;
    end else if (step_fire) begin
      phase_q    <= phase_d;
      wait_q     <= wait_d;
      bit_q      <= bit_d;
      shift_q    <= shift_d;
      ack_flag_q <= ack_flag_d;
      recv_q     <= recv_d;
      scl_q      <= scl_d;
      sda_q      <= sda_d;
      ack_send_q <= ack_send_d;
    end
  end

  // Output register: hold the word until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step_fire) begin
      out_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_fire) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = res_q;

  // A finished command never reports busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.done_res |-> !res_q.busy_res)
    else $error("done word reports busy");

  // A command taken while idle is never refused
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_fire && (phase_q == PhIdle) |=> !res_q.refused)
    else $error("idle command refused");

  // Clock stretching holds the write bit phase while SCL reads low
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_fire && (phase_q == PhWStretch) && !item_i.scl_in |=> phase_q == PhWStretch)
    else $error("stretch phase left with SCL low");

  // Bit counter stays within one byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_q <= 4'd8)
    else $error("bit counter overrun");

endmodule

### dv/i2cm_result_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// i2cm_result_check
// Watches the command, result and configuration channels of the I2C
// bit-level master. Each accepted tick word runs through a cycle-exact model
// of the bus sequencer. Each accepted result word is compared against the
// oldest predicted word.
// ----------------------------------------------------------------------------
module i2cm_result_check (
  input  logic        clk_i,
  input  logic        rst_ni,
  i2cm_cmd_if         cmd,
  i2cm_res_if         res,
  i2cm_cfg_if         cfg,
  output int unsigned mismatch_cnt_o,
  output int unsigned pending_o,
  output logic        seq_busy_o,
  output int unsigned words_checked_o,
  output int unsigned cmds_done_o,
  output int unsigned refusals_o
);

  // Bus sequencer phases, in the order the sequencer steps through them
  typedef enum logic [4:0] {
    PhIdle, PhStartRelScl, PhStartPullSda, PhStopPullSda, PhStopRelScl,
    PhStopRelSda, PhWrSclLow, PhWrSetSda, PhWrSclHigh, PhWrStretch,
    PhWaSclLow, PhWaRelSda, PhWaSclHigh, PhWaStretch, PhWaSclLow2,
    PhRdSclLow, PhRdSclHigh, PhRdStretch, PhRaSclLow, PhRaSetSda,
    PhRaSclHigh, PhRaSclLow2
  } phase_e;

  // Sequencer model state
  logic [i2cm_pkg::WaitW-1:0] short_ticks, long_ticks, hold_left;
  phase_e                     phase_q;
  logic [3:0]                 bits_done;
  logic [7:0]                 shifter, last_rx;
  logic                       ack_latched, scl_low_q, sda_low_q, ack_to_drive;

  i2cm_pkg::result_t          expected_words[$];

  initial begin
    mismatch_cnt_o  = 0;
    words_checked_o = 0;
    cmds_done_o     = 0;
    refusals_o      = 0;
    pending_o       = 0;
    seq_busy_o      = 1'b0;
  end

  function automatic void clear_sequencer();
    short_ticks  = i2cm_pkg::ShortWaitRst;
    long_ticks   = i2cm_pkg::LongWaitRst;
    hold_left    = '0;
    phase_q      = PhIdle;
    bits_done    = '0;
    shifter      = '0;
    last_rx      = '0;
    ack_latched  = 1'b0;
    scl_low_q    = 1'b0;
    sda_low_q    = 1'b0;
    ack_to_drive = 1'b0;
  endfunction

  // Perform the pin action of a phase and load its hold time
  function automatic void take_action(phase_e p);
    phase_q   = p;
    hold_left = '0;
    case (p)
      PhStartRelScl:  begin scl_low_q = 1'b0; hold_left = long_ticks;  end
      PhStartPullSda: begin sda_low_q = 1'b1; hold_left = long_ticks;  end
      PhStopPullSda:  begin sda_low_q = 1'b1; hold_left = long_ticks;  end
      PhStopRelScl:   begin scl_low_q = 1'b0; hold_left = short_ticks; end
      PhStopRelSda:   begin sda_low_q = 1'b0; hold_left = long_ticks;  end
      PhWrSclLow:     begin scl_low_q = 1'b1; hold_left = short_ticks; end
      PhWrSetSda:     begin sda_low_q = ~shifter[7]; hold_left = long_ticks; end
      PhWrSclHigh:    begin scl_low_q = 1'b0; hold_left = long_ticks;  end
      PhWaSclLow:     begin scl_low_q = 1'b1; hold_left = short_ticks; end
      PhWaRelSda:     begin sda_low_q = 1'b0; hold_left = long_ticks;  end
      PhWaSclHigh:    begin scl_low_q = 1'b0; hold_left = long_ticks;  end
      PhWaSclLow2:    begin scl_low_q = 1'b1; hold_left = long_ticks;  end
      PhRdSclLow:     begin scl_low_q = 1'b1; hold_left = long_ticks;  end
      PhRdSclHigh:    begin scl_low_q = 1'b0; hold_left = long_ticks;  end
      PhRaSclLow:     begin scl_low_q = 1'b1; hold_left = short_ticks; end
      PhRaSetSda:     begin sda_low_q = ack_to_drive; hold_left = long_ticks; end
      PhRaSclHigh:    begin scl_low_q = 1'b0; hold_left = long_ticks;  end
      PhRaSclLow2:    begin scl_low_q = 1'b1; hold_left = long_ticks;  end
      default: ;
    endcase
  endfunction

  // Advance the sequencer by one tick word and return the result word
  function automatic i2cm_pkg::result_t step_sequencer(i2cm_pkg::item_t w);
    i2cm_pkg::result_t r;
    logic              done, refused;
    done    = 1'b0;
    refused = 1'b0;
    if (phase_q == PhIdle) begin
      case (w.operation)
        i2cm_pkg::OpStart: take_action(PhStartRelScl);
        i2cm_pkg::OpStop:  take_action(PhStopPullSda);
        i2cm_pkg::OpWrite: begin
          shifter   = w.tx_byte;
          bits_done = '0;
          take_action(PhWrSclLow);
        end
        i2cm_pkg::OpRead: begin
          shifter      = '0;
          bits_done    = '0;
          ack_to_drive = w.send_ack;
          take_action(PhRdSclLow);
        end
        default: ;
      endcase
    end else begin
      refused = (w.operation >= i2cm_pkg::OpStart) && (w.operation <= i2cm_pkg::OpRead);
      if (phase_q == PhWrStretch) begin
        // hold until the slave lets SCL go high
        if (w.scl_in) begin
          shifter   = shifter << 1;
          bits_done = bits_done + 4'd1;
          take_action(bits_done < 4'd8 ? PhWrSclLow : PhWaSclLow);
        end
      end else if (phase_q == PhWaStretch) begin
        if (w.scl_in) begin
          ack_latched = ~w.sda_in;
          take_action(PhWaSclLow2);
        end
      end else if (phase_q == PhRdStretch) begin
        if (w.scl_in) begin
          if (w.sda_in) shifter = shifter | (i2cm_pkg::MsbMask >> bits_done[2:0]);
          bits_done = bits_done + 4'd1;
          take_action(bits_done < 4'd8 ? PhRdSclLow : PhRaSclLow);
        end
      end else if (hold_left > 1) begin
        hold_left = hold_left - 1'b1;
      end else if (phase_q == PhStartPullSda || phase_q == PhStopRelSda ||
                   phase_q == PhWaSclLow2 || phase_q == PhRaSclLow2) begin
        if (phase_q == PhRaSclLow2) last_rx = shifter;
        phase_q   = PhIdle;
        hold_left = '0;
        done      = 1'b1;
      end else begin
        take_action(phase_e'(phase_q + 1));
      end
    end
    r.scl_drive_low = scl_low_q;
    r.sda_drive_low = sda_low_q;
    r.busy_res      = (phase_q != PhIdle);
    r.done_res      = done;
    r.rx_byte       = last_rx;
    r.ack_seen      = ack_latched;
    r.refused       = refused;
    return r;
  endfunction

  function automatic string show(i2cm_pkg::result_t r);
    return $sformatf("scl=%0b sda=%0b busy=%0b done=%0b rx=%02h ack=%0b refused=%0b",
                     r.scl_drive_low, r.sda_drive_low, r.busy_res, r.done_res,
                     r.rx_byte, r.ack_seen, r.refused);
  endfunction

  // Track config writes, predict on each tick word, compare each result word
  always @(posedge clk_i or negedge rst_ni) begin
    i2cm_pkg::item_t   w;
    i2cm_pkg::result_t got, want;
    if (!rst_ni) begin
      clear_sequencer();
      expected_words.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == i2cm_pkg::CfgShortWait) short_ticks = cfg.data;
        else if (cfg.index == i2cm_pkg::CfgLongWait) long_ticks = cfg.data;
      end
      if (cmd.valid && cmd.ready) begin
        w.operation = cmd.operation;
        w.tx_byte   = cmd.tx_byte;
        w.send_ack  = cmd.send_ack;
        w.scl_in    = cmd.scl_in;
        w.sda_in    = cmd.sda_in;
        want = step_sequencer(w);
        if (want.done_res) cmds_done_o++;
        if (want.refused) refusals_o++;
        expected_words.push_back(want);
      end
      if (res.valid && res.ready) begin
        got.scl_drive_low = res.scl_drive_low;
        got.sda_drive_low = res.sda_drive_low;
        got.busy_res      = res.busy_res;
        got.done_res      = res.done_res;
        got.rx_byte       = res.rx_byte;
        got.ack_seen      = res.ack_seen;
        got.refused       = res.refused;
        if (expected_words.size() == 0) begin
          mismatch_cnt_o++;
          $display("%0t: expected no word, actual %s", $time, show(got));
        end else begin
          want = expected_words.pop_front();
          words_checked_o++;
          if (got !== want) begin
            mismatch_cnt_o++;
            $display("%0t: word %0d expected %s, actual %s", $time, words_checked_o,
                     show(want), show(got));
          end
        end
      end
      pending_o  = expected_words.size();
      seq_busy_o = (phase_q != PhIdle);
    end
  end

endmodule

### dv/tb_i2c_bit_level_master.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_i2c_bit_level_master
// Drives tick words, config writes and result back-pressure into the I2C
// bit-level master. Directed bus transfers come first, then zero and long
// hold times, then random transfers with stretching, refusals and hold-offs.
// ----------------------------------------------------------------------------
module tb_i2c_bit_level_master;

  localparam int unsigned CycleLimit    = 2_000_000;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned PhaseTicks    = 150;

  typedef enum logic [1:0] {SdaRandom, SdaHigh, SdaLow} sda_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  i2cm_cmd_if cmd_if();
  i2cm_res_if res_if();
  i2cm_cfg_if cfg_if();

  int unsigned mismatches, pending, words_checked, cmds_done, refusals;
  logic        seq_busy;

  // Stimulus knobs
  bit          idling;
  bit          hold_req;
  int unsigned holds_done;
  int unsigned cmd_pct;
  int unsigned scl_low_pct;
  int unsigned stuck_ticks;
  sda_mode_e   sda_mode;
  int unsigned ticks_sent;
  int unsigned cycles;

  i2c_bit_level_master dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  i2cm_result_check u_result_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd             (cmd_if),
    .res             (res_if),
    .cfg             (cfg_if),
    .mismatch_cnt_o  (mismatches),
    .pending_o       (pending),
    .seq_busy_o      (seq_busy),
    .words_checked_o (words_checked),
    .cmds_done_o     (cmds_done),
    .refusals_o      (refusals)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Timeout after %0d cycles, %0d words outstanding", cycles, pending);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result side: random stalls, and a long hold-off on request
  initial begin
    int unsigned stall;
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_req) begin
        stall    = HoldOffCycles;
        hold_req = 1'b0;
        holds_done++;
      end else begin
        stall = idling ? $urandom_range(0, 7) : 0;
      end
      if (stall != 0) begin
        res_if.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      res_if.ready = 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
      @(negedge clk_i);
    end
  end

  // Offer one tick word after a random gap; entered and left at a falling edge
  task automatic send_tick(i2cm_pkg::item_t w);
    int unsigned gap;
    gap = idling ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      cmd_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cmd_if.valid     = 1'b1;
    cmd_if.operation = w.operation;
    cmd_if.tx_byte   = w.tx_byte;
    cmd_if.send_ack  = w.send_ack;
    cmd_if.scl_in    = w.scl_in;
    cmd_if.sda_in    = w.sda_in;
    do @(posedge clk_i); while (!cmd_if.ready);
    ticks_sent++;
    @(negedge clk_i);
  endtask

  // Tick word while a command runs: pin levels, stray commands, stuck SCL
  function automatic i2cm_pkg::item_t bus_tick();
    i2cm_pkg::item_t w;
    w.operation = ($urandom_range(0, 99) < cmd_pct) ? 3'($urandom_range(1, 7))
                                                    : i2cm_pkg::OpTick;
    w.tx_byte   = 8'($urandom);
    w.send_ack  = 1'($urandom);
    if (stuck_ticks != 0) begin
      w.scl_in = 1'b0;
      stuck_ticks--;
    end else begin
      w.scl_in = ($urandom_range(0, 99) >= scl_low_pct);
    end
    case (sda_mode)
      SdaHigh: w.sda_in = 1'b1;
      SdaLow:  w.sda_in = 1'b0;
      default: w.sda_in = 1'($urandom);
    endcase
    return w;
  endfunction

  // Issue a command on an idle sequencer and tick it until it finishes
  task automatic run_cmd(logic [2:0] op, logic [7:0] tx, logic ack);
    i2cm_pkg::item_t w;
    w           = bus_tick();
    w.operation = op;
    w.tx_byte   = tx;
    w.send_ack  = ack;
    send_tick(w);
    while (seq_busy) send_tick(bus_tick());
  endtask

  // Let every predicted word arrive, then allow for the pipeline
  task automatic drain();
    cmd_if.valid = 1'b0;
    wait (pending == 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [i2cm_pkg::WaitW-1:0] val);
    drain();
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = val;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  task automatic set_waits(logic [i2cm_pkg::WaitW-1:0] short_w,
                           logic [i2cm_pkg::WaitW-1:0] long_w);
    write_reg(i2cm_pkg::CfgShortWait, short_w);
    write_reg(i2cm_pkg::CfgLongWait, long_w);
  endtask

  // One random transfer: mostly start, bytes, stop; sometimes broken or noise
  task automatic random_transfer();
    int unsigned nbytes;
    idling      = ($urandom_range(0, 3) != 0);
    cmd_pct     = $urandom_range(0, 15);
    scl_low_pct = $urandom_range(0, 40);
    sda_mode    = SdaRandom;
    if ($urandom_range(0, 19) == 0) stuck_ticks = $urandom_range(10, 40);
    if ($urandom_range(0, 7) == 0) begin
      run_cmd(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom));
    end else begin
      run_cmd(i2cm_pkg::OpStart, 8'($urandom), 1'($urandom));
      nbytes = $urandom_range(1, 3);
      repeat (nbytes) begin
        if ($urandom_range(0, 1) != 0) begin
          run_cmd(i2cm_pkg::OpWrite, 8'($urandom), 1'($urandom));
        end else begin
          run_cmd(i2cm_pkg::OpRead, 8'($urandom), 1'($urandom));
        end
        // repeated start
        if ($urandom_range(0, 9) == 0) run_cmd(i2cm_pkg::OpStart, 8'($urandom), 1'($urandom));
      end
      if ($urandom_range(0, 9) != 0) run_cmd(i2cm_pkg::OpStop, 8'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    int unsigned phase_start;
    cmd_if.valid     = 1'b0;
    cmd_if.operation = i2cm_pkg::OpTick;
    cmd_if.tx_byte   = '0;
    cmd_if.send_ack  = 1'b0;
    cmd_if.scl_in    = 1'b1;
    cmd_if.sda_in    = 1'b1;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = i2cm_pkg::CfgShortWait;
    cfg_if.data      = '0;
    idling           = 1'b1;
    hold_req         = 1'b0;
    holds_done       = 0;
    cmd_pct          = 10;
    scl_low_pct      = 20;
    stuck_ticks      = 0;
    sda_mode         = SdaRandom;
    ticks_sent       = 0;
    cycles           = 0;
    rst_ni           = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset hold times: idle ticks and unknown codes, then a full transfer
    run_cmd(i2cm_pkg::OpTick, 8'h00, 1'b0);
    run_cmd(3'd5, 8'hFF, 1'b1);
    run_cmd(3'd6, 8'h00, 1'b0);
    run_cmd(3'd7, 8'hFF, 1'b1);
    run_cmd(i2cm_pkg::OpStart, 8'h00, 1'b0);
    sda_mode = SdaLow;
    run_cmd(i2cm_pkg::OpWrite, 8'hFF, 1'b0);
    sda_mode = SdaHigh;
    cmd_pct  = 40;
    run_cmd(i2cm_pkg::OpWrite, 8'h00, 1'b1);
    cmd_pct  = 10;
    run_cmd(i2cm_pkg::OpRead, 8'h00, 1'b1);
    sda_mode = SdaLow;
    run_cmd(i2cm_pkg::OpRead, 8'hFF, 1'b0);
    // SCL held low by the slave well past the first data clock
    sda_mode    = SdaRandom;
    stuck_ticks = 40;
    run_cmd(i2cm_pkg::OpWrite, 8'hA5, 1'b0);
    run_cmd(i2cm_pkg::OpStop, 8'h00, 1'b0);
    run_cmd(i2cm_pkg::OpStop, 8'h00, 1'b0);

    // Zero hold times act as one tick
    set_waits(16'd0, 16'd0);
    run_cmd(i2cm_pkg::OpStart, 8'h00, 1'b0);
    run_cmd(i2cm_pkg::OpWrite, 8'h5A, 1'b0);
    run_cmd(i2cm_pkg::OpRead, 8'h00, 1'b1);
    run_cmd(i2cm_pkg::OpStop, 8'h00, 1'b0);

    // Long hold times, one register at a time, without idling
    idling = 1'b0;
    set_waits(16'h0103, 16'd1);
    run_cmd(i2cm_pkg::OpStop, 8'h00, 1'b0);
    set_waits(16'd1, 16'd40);
    run_cmd(i2cm_pkg::OpStart, 8'h00, 1'b0);

    // Random transfers across several hold-time settings
    for (int i = 0; i < 4; i++) begin
      idling = 1'b1;
      case (i)
        0: set_waits(16'd1, 16'd1);
        3: set_waits(i2cm_pkg::ShortWaitRst, i2cm_pkg::LongWaitRst);
        default: set_waits(16'($urandom_range(1, 4)), 16'($urandom_range(1, 6)));
      endcase
      // fill the block while results are held back
      if (i == 1) begin
        idling   = 1'b0;
        hold_req = 1'b1;
      end
      phase_start = ticks_sent;
      while (ticks_sent - phase_start < PhaseTicks) random_transfer();
    end

    drain();
    repeat (8) @(posedge clk_i);
    $display("Sent %0d tick words, checked %0d result words in %0d cycles",
             ticks_sent, words_checked, cycles);
    $display("Commands completed %0d, refused %0d, long hold-offs %0d",
             cmds_done, refusals, holds_done);
    if (mismatches == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/i2cm_pkg.sv
hw/rtl/i2cm_if.sv
hw/rtl/i2cm_seq.sv
hw/rtl/i2c_bit_level_master.sv
dv/i2cm_result_check.sv
dv/tb_i2c_bit_level_master.sv
